### rtl/core/plsh_pkg.sv
// ----------------------------------------------------------------------------
// plsh_pkg
// Shared types and constants for the binary plist string header parser.
// ----------------------------------------------------------------------------
package plsh_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_MARKER  = 3'd1,
    PH_INTMARK = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_IDLE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_BADMAGIC = 3'd2,
    ST_BADFMT   = 3'd3,
    ST_BADLEN   = 3'd4,
    ST_BADISZ   = 3'd5,
    ST_TRUNC    = 3'd6
  } status_t;

  // one result item as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_t    status;
  } rec_t;

  localparam int MagicLen = 8;
  localparam logic [7:0] MAGIC [MagicLen] = '{
    8'h62, 8'h70, 8'h6c, 8'h69, 8'h73, 8'h74, 8'h30, 8'h30
  };

  localparam logic [3:0] FMT_ASCII   = 4'd5;
  localparam logic [3:0] FMT_UTF16   = 4'd6;
  localparam logic [3:0] FMT_INT     = 4'd1;
  localparam logic [3:0] LOW_EXT     = 4'd15;
  localparam logic [3:0] MAX_INT_POW = 4'd2;

  localparam int QueueDepth = 2;

endpackage

### rtl/core/plsh_if.sv
// ----------------------------------------------------------------------------
// plsh_if
// Valid/ready channels for raw input bytes and for parser results.
// ----------------------------------------------------------------------------
interface plsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface plsh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       end_of_value;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output end_of_value, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  input end_of_value, output ready);
endinterface

### rtl/core/plsh_front.sv
// ----------------------------------------------------------------------------
// plsh_front
// Accepts raw bytes, walks the header phases and classifies each byte into
// zero or one result record pushed to the queue.
// ----------------------------------------------------------------------------
module plsh_front (
  input  logic             clk,
  input  logic             rst_n,
  plsh_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output plsh_pkg::rec_t   q_rec
);

  plsh_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        two_r, two_nxt;
  logic [2:0]  len_left_r, len_left_nxt;
  logic [31:0] len_acc_r, len_acc_nxt;
  logic [32:0] pay_left_r, pay_left_nxt;

  logic            accept;
  logic [7:0]      b;
  logic [3:0]      hi_nib;
  logic [3:0]      lo_nib;
  logic [31:0]     acc_shift;
  logic [32:0]     pay_dec;
  logic [31:0]     chars;
  logic            start;
  logic [32:0]     pay_start;
  logic            emit;
  plsh_pkg::status_t st;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign hi_nib      = b[7:4];
  assign lo_nib      = b[3:0];
  assign acc_shift   = {len_acc_r[23:0], b};
  assign pay_dec     = pay_left_r - 33'd1;

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    two_nxt      = two_r;
    len_left_nxt = len_left_r;
    len_acc_nxt  = len_acc_r;
    pay_left_nxt = pay_left_r;
    st           = plsh_pkg::ST_BUSY;
    emit         = 1'b0;
    start        = 1'b0;
    chars        = 32'd0;
    q_rec.data   = 8'd0;
    q_rec.valid  = 1'b0;

    case (phase_r)
      plsh_pkg::PH_MAGIC: begin
        if (b != plsh_pkg::MAGIC[idx_r]) begin
          st        = plsh_pkg::ST_BADMAGIC;
          phase_nxt = plsh_pkg::PH_IDLE;
        end else begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'(plsh_pkg::MagicLen - 1)) begin
            phase_nxt = plsh_pkg::PH_MARKER;
          end
        end
      end
      plsh_pkg::PH_MARKER: begin
        if (!(hi_nib inside {plsh_pkg::FMT_ASCII, plsh_pkg::FMT_UTF16})) begin
          st        = plsh_pkg::ST_BADFMT;
          phase_nxt = plsh_pkg::PH_IDLE;
        end else begin
          two_nxt = (hi_nib == plsh_pkg::FMT_UTF16);
          if (lo_nib == plsh_pkg::LOW_EXT) begin
            phase_nxt = plsh_pkg::PH_INTMARK;
          end else begin
            start = 1'b1;
            chars = {28'd0, lo_nib};
          end
        end
      end
      plsh_pkg::PH_INTMARK: begin
        if (hi_nib != plsh_pkg::FMT_INT) begin
          st        = plsh_pkg::ST_BADLEN;
          phase_nxt = plsh_pkg::PH_IDLE;
        end else if (lo_nib > plsh_pkg::MAX_INT_POW) begin
          st        = plsh_pkg::ST_BADISZ;
          phase_nxt = plsh_pkg::PH_IDLE;
        end else begin
          len_left_nxt = 3'd1 << lo_nib[1:0];
          len_acc_nxt  = 32'd0;
          phase_nxt    = plsh_pkg::PH_LENGTH;
        end
      end
      plsh_pkg::PH_LENGTH: begin
        len_acc_nxt  = acc_shift;
        len_left_nxt = len_left_r - 3'd1;
        if (len_left_r == 3'd1) begin
          start = 1'b1;
          chars = acc_shift;
        end
      end
      plsh_pkg::PH_PAYLOAD: begin
        q_rec.data   = b;
        q_rec.valid  = 1'b1;
        emit         = 1'b1;
        pay_left_nxt = pay_dec;
        if (pay_dec == 33'd0) begin
          st        = plsh_pkg::ST_DONE;
          phase_nxt = plsh_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = plsh_pkg::PH_IDLE;
      end
    endcase

    pay_start = two_nxt ? {chars, 1'b0} : {1'b0, chars};
    if (start) begin
      pay_left_nxt = pay_start;
      if (pay_start == 33'd0) begin
        st        = plsh_pkg::ST_DONE;
        phase_nxt = plsh_pkg::PH_IDLE;
      end else begin
        phase_nxt = plsh_pkg::PH_PAYLOAD;
      end
    end

    if (st != plsh_pkg::ST_BUSY) begin
      emit = 1'b1;
    end
    if (in_ch.last_byte && phase_r != plsh_pkg::PH_IDLE && st == plsh_pkg::ST_BUSY) begin
      st   = plsh_pkg::ST_TRUNC;
      emit = 1'b1;
    end
    if (in_ch.last_byte) begin
      phase_nxt    = plsh_pkg::PH_MAGIC;
      idx_nxt      = 3'd0;
      two_nxt      = 1'b0;
      len_left_nxt = 3'd0;
      len_acc_nxt  = 32'd0;
      pay_left_nxt = 33'd0;
    end

    q_rec.status = st;
    q_push       = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= plsh_pkg::PH_MAGIC;
      idx_r      <= 3'd0;
      two_r      <= 1'b0;
      len_left_r <= 3'd0;
      len_acc_r  <= 32'd0;
      pay_left_r <= 33'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      two_r      <= two_nxt;
      len_left_r <= len_left_nxt;
      len_acc_r  <= len_acc_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

endmodule

### rtl/core/plsh_queue.sv
// ----------------------------------------------------------------------------
// plsh_queue
// Two-entry result queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
module plsh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  plsh_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output plsh_pkg::rec_t head_rec
);

  plsh_pkg::rec_t entry_r [plsh_pkg::QueueDepth];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (count_r == 2'(plsh_pkg::QueueDepth));
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

### rtl/core/plsh_back.sv
// ----------------------------------------------------------------------------
// plsh_back
// Output stage: pops queued records, expands them to result fields and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
module plsh_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  plsh_pkg::rec_t q_head,
  output logic           q_pop,
  plsh_out_if.source     out_ch
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r;
  logic [2:0] status_r;
  logic       eov_r;
  logic       load;

  assign load  = !q_empty && (!valid_r || out_ch.ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= q_head.data;
      bvalid_r <= q_head.valid;
      status_r <= q_head.status;
      eov_r    <= (q_head.status != plsh_pkg::ST_BUSY);
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.out_byte     = byte_r;
  assign out_ch.byte_valid   = bvalid_r;
  assign out_ch.status       = status_r;
  assign out_ch.end_of_value = eov_r;

endmodule

### rtl/core/plist_string_header_parser_core.sv
// Each byte's result record is registered first in the queue and then in the output register.
// Throughput: one byte per cycle while the queue is not full; the front parses each byte in a single step.
// A two-entry queue and the output register let input and output stall apart.
// Reset (rst_n low, synchronous) returns the parser to the magic phase and
// empties the queue and the output register.
// ----------------------------------------------------------------------------
// plist_string_header_parser_core
// Binary plist string header decoder: magic, marker, length, payload bytes.
// ----------------------------------------------------------------------------
module plist_string_header_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  plsh_in_if.sink    in_ch,
  plsh_out_if.source out_ch
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  plsh_pkg::rec_t push_rec;
  plsh_pkg::rec_t head_rec;

  plsh_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (push_rec)
  );

  plsh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (head_rec)
  );

  plsh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (head_rec),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### sim/plist_string_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// plist_string_header_parser_core_tb
// Drives whole plist string values byte by byte through the parser and
// checks every result item against a cycle-free decoder kept in the bench.
// A table of directed values (signature, marker and length forms, every error,
// early ends) runs first, then random values, mostly well formed, with random
// idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module plist_string_header_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 100;
  localparam int ITEM_TARGET = 950;
  localparam logic [7:0] PLIST_SIG [8] = '{
    8'h62, 8'h70, 8'h6c, 8'h69, 8'h73, 8'h74, 8'h30, 8'h30
  };

  typedef struct packed {
    logic [7:0]        data;
    logic              valid;
    plsh_pkg::status_t status;
    logic              eov;
  } result_t;

  typedef struct {
    int                bad_sig_at;   // -1 keeps the signature intact
    logic [7:0]        marker;
    logic [7:0]        int_marker;
    logic [31:0]       count;
    int                payload_n;
    int                trail_n;
    int                cut_at;       // 0 sends the whole value
    plsh_pkg::status_t end_status;
  } value_spec_t;

  logic clk = 1'b0;
  logic rst_n;

  plsh_in_if  in_ch();
  plsh_out_if out_ch();

  plist_string_header_parser_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // decoder state
  plsh_pkg::phase_t dec_phase    = plsh_pkg::PH_MAGIC;
  logic [3:0]       dec_sig_idx  = '0;
  logic             dec_wide     = 1'b0;
  logic [2:0]       dec_len_left = '0;
  logic [31:0]      dec_len_acc  = '0;
  logic [32:0]      dec_pay_left = '0;

  result_t           pending_results[$];
  plsh_pkg::status_t final_status;
  value_spec_t       dir_rows [25];

  int errors = 0;
  int bytes_sent = 0;
  int values_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int ends_by_status [8];
  int send_idle_pct = 28;
  int recv_idle_pct = 77;
  logic hold_req = 1'b0;
  int hold_left = 0;

  function automatic plsh_pkg::status_t start_string(input logic [31:0] chars);
    dec_pay_left = dec_wide ? {chars, 1'b0} : {1'b0, chars};
    if (dec_pay_left == '0) begin
      dec_phase = plsh_pkg::PH_IDLE;
      return plsh_pkg::ST_DONE;
    end
    dec_phase = plsh_pkg::PH_PAYLOAD;
    return plsh_pkg::ST_BUSY;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    plsh_pkg::status_t st;
    result_t r;
    logic    emit;
    logic    was_idle;
    st = plsh_pkg::ST_BUSY;
    r = '0;
    emit = 1'b0;
    was_idle = (dec_phase == plsh_pkg::PH_IDLE);
    case (dec_phase)
      plsh_pkg::PH_MAGIC: begin
        if (b != PLIST_SIG[dec_sig_idx[2:0]]) begin
          st = plsh_pkg::ST_BADMAGIC;
          dec_phase = plsh_pkg::PH_IDLE;
        end else if (dec_sig_idx == 4'd7) begin
          dec_sig_idx = '0;
          dec_phase = plsh_pkg::PH_MARKER;
        end else begin
          dec_sig_idx = dec_sig_idx + 4'd1;
        end
      end
      plsh_pkg::PH_MARKER: begin
        if (b[7:4] != plsh_pkg::FMT_ASCII && b[7:4] != plsh_pkg::FMT_UTF16) begin
          st = plsh_pkg::ST_BADFMT;
          dec_phase = plsh_pkg::PH_IDLE;
        end else begin
          dec_wide = (b[7:4] == plsh_pkg::FMT_UTF16);
          if (b[3:0] == plsh_pkg::LOW_EXT) dec_phase = plsh_pkg::PH_INTMARK;
          else st = start_string({28'd0, b[3:0]});
        end
      end
      plsh_pkg::PH_INTMARK: begin
        if (b[7:4] != plsh_pkg::FMT_INT) begin
          st = plsh_pkg::ST_BADLEN;
          dec_phase = plsh_pkg::PH_IDLE;
        end else if (b[3:0] > plsh_pkg::MAX_INT_POW) begin
          st = plsh_pkg::ST_BADISZ;
          dec_phase = plsh_pkg::PH_IDLE;
        end else begin
          dec_len_left = 3'd1 << b[1:0];
          dec_len_acc = '0;
          dec_phase = plsh_pkg::PH_LENGTH;
        end
      end
      plsh_pkg::PH_LENGTH: begin
        dec_len_acc = {dec_len_acc[23:0], b};
        dec_len_left = dec_len_left - 3'd1;
        if (dec_len_left == '0) st = start_string(dec_len_acc);
      end
      plsh_pkg::PH_PAYLOAD: begin
        r.data = b;
        r.valid = 1'b1;
        emit = 1'b1;
        dec_pay_left = dec_pay_left - 33'd1;
        if (dec_pay_left == '0) begin
          st = plsh_pkg::ST_DONE;
          dec_phase = plsh_pkg::PH_IDLE;
        end
      end
      default: dec_phase = plsh_pkg::PH_IDLE;
    endcase
    if (st != plsh_pkg::ST_BUSY) emit = 1'b1;
    if (last && !was_idle && st == plsh_pkg::ST_BUSY) begin
      st = plsh_pkg::ST_TRUNC;
      emit = 1'b1;
    end
    if (last) begin
      dec_phase = plsh_pkg::PH_MAGIC;
      dec_sig_idx = '0;
      dec_wide = 1'b0;
      dec_len_left = '0;
      dec_len_acc = '0;
      dec_pay_left = '0;
    end
    if (emit) begin
      r.status = st;
      r.eov = (st != plsh_pkg::ST_BUSY);
      if (r.eov) begin
        ends_by_status[st]++;
        final_status = st;
      end
      pending_results.push_back(r);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_value(input value_spec_t s);
    logic [7:0] seq[$];
    int nlen;
    for (int i = 0; i < 8; i++)
      seq.push_back(PLIST_SIG[i] ^ ((i == s.bad_sig_at) ? 8'h01 : 8'h00));
    seq.push_back(s.marker);
    if (s.marker[3:0] == plsh_pkg::LOW_EXT) begin
      seq.push_back(s.int_marker);
      if (s.int_marker[7:4] == plsh_pkg::FMT_INT &&
          s.int_marker[3:0] <= plsh_pkg::MAX_INT_POW) begin
        nlen = 1 << s.int_marker[1:0];
        for (int k = nlen - 1; k >= 0; k--) seq.push_back(s.count[8*k +: 8]);
      end
    end
    for (int i = 0; i < s.payload_n; i++) seq.push_back(8'($urandom));
    for (int i = 0; i < s.trail_n; i++) seq.push_back(8'($urandom));
    while (s.cut_at > 0 && seq.size() > s.cut_at) seq.delete(seq.size() - 1);
    for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
    values_sent++;
  endtask

  function automatic value_spec_t random_spec();
    value_spec_t s;
    logic [31:0] chars;
    logic [32:0] need;
    s.bad_sig_at = ($urandom_range(99) < 5) ? int'($urandom_range(7)) : -1;
    s.marker[7:4] = ($urandom_range(99) < 8) ? 4'($urandom) :
                    ($urandom_range(1) ? plsh_pkg::FMT_UTF16 : plsh_pkg::FMT_ASCII);
    s.marker[3:0] = ($urandom_range(3) == 0) ? plsh_pkg::LOW_EXT : 4'($urandom);
    s.int_marker = ($urandom_range(99) < 10) ? 8'($urandom) :
                   {plsh_pkg::FMT_INT, 4'($urandom_range(2))};
    s.count = ($urandom_range(99) < 5) ? $urandom : 32'($urandom_range(12));
    case (s.int_marker[3:0])
      4'd0:    chars = {24'd0, s.count[7:0]};
      4'd1:    chars = {16'd0, s.count[15:0]};
      default: chars = s.count;
    endcase
    if (s.marker[3:0] != plsh_pkg::LOW_EXT) chars = {28'd0, s.marker[3:0]};
    need = (s.marker[7:4] == plsh_pkg::FMT_UTF16) ? {chars, 1'b0} : {1'b0, chars};
    if (need > 33'd40) s.payload_n = $urandom_range(6);
    else if ($urandom_range(9) == 0) s.payload_n = $urandom_range(int'(need));
    else s.payload_n = int'(need);
    s.trail_n = $urandom_range(1) ? 0 : int'($urandom_range(3, 1));
    s.cut_at = ($urandom_range(99) < 4) ? int'($urandom_range(12, 1)) : 0;
    s.end_status = plsh_pkg::ST_BUSY;
    return s;
  endfunction

  task automatic run_random(input int stop_at);
    int noise_n;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 4) begin
        noise_n = $urandom_range(6, 1);
        for (int k = 0; k < noise_n; k++) send_byte(8'($urandom), k == noise_n - 1);
      end else begin
        send_value(random_spec());
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result side: random ready, long hold on request, in-order compare
  initial begin
    result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item: byte %h valid %b status %0d eov %b",
                 out_ch.out_byte, out_ch.byte_valid, out_ch.status, out_ch.end_of_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.byte_valid !== want.valid) begin
            $error("byte_valid: expected %b, got %b", want.valid, out_ch.byte_valid);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.end_of_value !== want.eov) begin
            $error("end_of_value: expected %b, got %b", want.eov, out_ch.end_of_value);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding",
           cycle_count, pending_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int rand_base;
    int rand_span;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    dir_rows = '{
      '{-1, 8'h53, 8'h00, 32'd0,          3, 0,  0, plsh_pkg::ST_DONE},  // short byte string
      '{-1, 8'h50, 8'h00, 32'd0,          0, 2,  0, plsh_pkg::ST_DONE},  // empty, trailing
      '{-1, 8'h60, 8'h00, 32'd0,          0, 0,  0, plsh_pkg::ST_DONE},  // empty, two-byte
      '{-1, 8'h62, 8'h00, 32'd0,          4, 1,  0, plsh_pkg::ST_DONE},
      '{-1, 8'h5E, 8'h00, 32'd0,         14, 0,  0, plsh_pkg::ST_DONE},  // largest inline
      '{-1, 8'h5F, 8'h10, 32'd0,          0, 1,  0, plsh_pkg::ST_DONE},  // 1-byte len, empty
      '{-1, 8'h6F, 8'h11, 32'd3,          6, 0,  0, plsh_pkg::ST_DONE},  // 2-byte length
      '{-1, 8'h5F, 8'h12, 32'd5,          5, 3,  0, plsh_pkg::ST_DONE},  // 4-byte length
      '{ 0, 8'h51, 8'h00, 32'd0,          1, 2,  0, plsh_pkg::ST_BADMAGIC},
      '{ 7, 8'h51, 8'h00, 32'd0,          1, 2,  0, plsh_pkg::ST_BADMAGIC},
      '{-1, 8'h4F, 8'h00, 32'd0,          0, 1,  0, plsh_pkg::ST_BADFMT},
      '{-1, 8'hFF, 8'h10, 32'd0,          0, 0,  0, plsh_pkg::ST_BADFMT},
      '{-1, 8'h00, 8'h00, 32'd0,          0, 0,  0, plsh_pkg::ST_BADFMT},
      '{-1, 8'h5F, 8'h20, 32'd0,          0, 1,  0, plsh_pkg::ST_BADLEN},
      '{-1, 8'h5F, 8'hFF, 32'd0,          0, 0,  0, plsh_pkg::ST_BADLEN},
      '{-1, 8'h6F, 8'h13, 32'd0,          0, 1,  0, plsh_pkg::ST_BADISZ},
      '{-1, 8'h5F, 8'h1F, 32'd0,          0, 0,  0, plsh_pkg::ST_BADISZ},
      '{-1, 8'h6F, 8'h12, 32'hFFFF_FFFF,  3, 0,  0, plsh_pkg::ST_TRUNC},  // max length, wide
      '{-1, 8'h5F, 8'h11, 32'h0000_FFFF,  0, 0, 11, plsh_pkg::ST_TRUNC},  // ends in length
      '{-1, 8'h53, 8'h00, 32'd0,          3, 0,  3, plsh_pkg::ST_TRUNC},  // ends in signature
      '{-1, 8'h53, 8'h00, 32'd0,          3, 0,  9, plsh_pkg::ST_TRUNC},  // ends on marker
      '{-1, 8'h5F, 8'h10, 32'd7,          7, 0, 10, plsh_pkg::ST_TRUNC},  // ends on int marker
      '{-1, 8'h53, 8'h00, 32'd0,          3, 0,  1, plsh_pkg::ST_TRUNC},  // single byte value
      '{ 0, 8'h53, 8'h00, 32'd0,          3, 0,  1, plsh_pkg::ST_BADMAGIC},
      '{-1, 8'h5F, 8'h12, 32'd2,          0, 0,  0, plsh_pkg::ST_TRUNC}   // ends on last len
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      final_status = plsh_pkg::ST_BUSY;
      send_value(dir_rows[i]);
      if (final_status != dir_rows[i].end_status) begin
        $error("table row %0d: end status expected %0d, decoder gave %0d",
               i, dir_rows[i].end_status, final_status);
        errors++;
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    rand_base = bytes_sent;
    rand_span = (ITEM_TARGET > rand_base) ? ITEM_TARGET - rand_base : 0;
    run_random(rand_base + rand_span / 3);
    in_ch.valid <= 1'b0;
    wait_drained();

    send_idle_pct = 77;
    recv_idle_pct = 28;
    run_random(rand_base + (2 * rand_span) / 3);
    in_ch.valid <= 1'b0;
    wait_drained();

    // no idling; the receiver holds off first so the input side backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(rand_base + rand_span);
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);

    $display("%0d values in %0d bytes, %0d result items checked, %0d cycles",
             values_sent, bytes_sent, results_checked, cycle_count);
    $display("ends: done %0d, signature %0d, format %0d, int marker %0d, size %0d, early %0d",
             ends_by_status[plsh_pkg::ST_DONE], ends_by_status[plsh_pkg::ST_BADMAGIC],
             ends_by_status[plsh_pkg::ST_BADFMT], ends_by_status[plsh_pkg::ST_BADLEN],
             ends_by_status[plsh_pkg::ST_BADISZ], ends_by_status[plsh_pkg::ST_TRUNC]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/plsh_pkg.sv
rtl/core/plsh_if.sv
rtl/core/plsh_front.sv
rtl/core/plsh_queue.sv
rtl/core/plsh_back.sv
rtl/core/plist_string_header_parser_core.sv
sim/plist_string_header_parser_core_tb.sv
